FILE: rtl/core/gprb_pkg.sv
// Shared types, register codes and lock sequence codes of the GPIO port register block.
package gprb_pkg;

    localparam int PIN_COUNT = 16;
    localparam logic [15:0] PIN_MASK = 16'((64'd1 << PIN_COUNT) - 64'd1);
    localparam logic [31:0] CONFIG_RESET = 32'h4444_4444;
    localparam logic [3:0] NIBBLE = 4'b1111;
    localparam int KEY_POS = 16;

    localparam logic OP_READ = 1'b0;
    localparam logic OP_WRITE = 1'b1;

    localparam logic [2:0] REG_CFG_LOW = 3'd0;
    localparam logic [2:0] REG_CFG_HIGH = 3'd1;
    localparam logic [2:0] REG_INPUT = 3'd2;
    localparam logic [2:0] REG_OUTPUT = 3'd3;
    localparam logic [2:0] REG_SET_RESET = 3'd4;
    localparam logic [2:0] REG_RESET = 3'd5;
    localparam logic [2:0] REG_LOCK = 3'd6;

    localparam logic [2:0] LK_IDLE = 3'd0;
    localparam logic [2:0] LK_ARMED = 3'd1;
    localparam logic [2:0] LK_CLEARED = 3'd2;
    localparam logic [2:0] LK_LOCKED = 3'd3;
    localparam logic [2:0] LK_KEYED = 3'd4;

    typedef struct packed {
        logic        op;
        logic [2:0]  reg_index;
        logic [31:0] write_data;
        logic [15:0] pin_levels;
    } req_t;

    typedef struct packed {
        logic [31:0] read_data;
        logic [15:0] pins_driven;
        logic        config_locked;
    } rsp_t;

    typedef struct packed {
        logic accept;
    } cmd_t;

endpackage

FILE: rtl/core/gprb_if.sv
// Request and result channel interfaces of the GPIO port register block.
interface gprb_req_if
    import gprb_pkg::*;
();
    logic valid;
    logic ready;
    req_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

interface gprb_rsp_if
    import gprb_pkg::*;
();
    logic valid;
    logic ready;
    rsp_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

FILE: rtl/core/gprb_ctrl.sv
// Handshake controller: tracks whether the result register holds an undelivered result.
module gprb_ctrl
    import gprb_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_ready,
    output logic rsp_valid,
    input  logic rsp_ready,
    output cmd_t cmd
);

    typedef enum logic [1:0] {
        ST_EMPTY = 2'b01,
        ST_FULL  = 2'b10
    } state_t;

    state_t state_reg;
    state_t state_next;

    // A new request may enter when no result is held, or when the held result leaves in the same cycle.
    assign req_ready  = (state_reg == ST_EMPTY) || rsp_ready;
    assign rsp_valid  = (state_reg == ST_FULL);
    assign cmd.accept = req_valid && req_ready;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_EMPTY:
            begin
                if (cmd.accept)
                begin
                    state_next = ST_FULL;
                end
            end
            ST_FULL:
            begin
                if (!cmd.accept && rsp_ready)
                begin
                    state_next = ST_EMPTY;
                end
            end
            default:
            begin
                state_next = ST_EMPTY;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_EMPTY;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

FILE: rtl/core/gprb_datapath.sv
// Register file, lock sequence and result register of the GPIO port register block.
module gprb_datapath
    import gprb_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  cmd_t cmd,
    input  req_t req,
    output rsp_t rsp
);

    logic [31:0] config_low_reg, config_low_next;
    logic [31:0] config_high_reg, config_high_next;
    logic [15:0] output_latch_reg, output_latch_next;
    logic [15:0] lock_mask_reg, lock_mask_next;
    logic        lock_key_reg, lock_key_next;
    logic [2:0]  lock_step_reg, lock_step_next;
    logic [15:0] pending_mask_reg, pending_mask_next;
    rsp_t        rsp_reg, rsp_next;

    logic        locked;
    logic [31:0] keep_low;
    logic [31:0] keep_high;
    logic [15:0] wr_mask;
    logic        wr_key;
    logic [31:0] rd;

    assign locked  = (lock_step_reg == LK_LOCKED) || (lock_step_reg == LK_KEYED);
    assign wr_mask = req.write_data[15:0] & PIN_MASK;
    assign wr_key  = req.write_data[KEY_POS];

    // Nibbles of masked pins are kept from the old word once the port is locked.
    always_comb
    begin
        for (int i = 0; i < 8; i++)
        begin
            keep_low[4*i +: 4]  = (locked && lock_mask_reg[i]) ? NIBBLE : 4'b0000;
            keep_high[4*i +: 4] = (locked && lock_mask_reg[8 + i]) ? NIBBLE : 4'b0000;
        end
    end

    always_comb
    begin
        config_low_next   = config_low_reg;
        config_high_next  = config_high_reg;
        output_latch_next = output_latch_reg;
        lock_mask_next    = lock_mask_reg;
        lock_key_next     = lock_key_reg;
        lock_step_next    = lock_step_reg;
        pending_mask_next = pending_mask_reg;
        rd                = 32'd0;

        if (req.op == OP_READ)
        begin
            case (req.reg_index)
                REG_CFG_LOW:  rd = config_low_reg;
                REG_CFG_HIGH: rd = config_high_reg;
                REG_INPUT:    rd = {16'd0, req.pin_levels & PIN_MASK};
                REG_OUTPUT:   rd = {16'd0, output_latch_reg};
                REG_LOCK:
                begin
                    rd = {15'd0, lock_key_reg, lock_mask_reg};
                    if (lock_step_reg == LK_LOCKED)
                    begin
                        lock_key_next  = 1'b1;
                        lock_step_next = LK_KEYED;
                    end
                end
                default:      rd = 32'd0;
            endcase
        end
        else
        begin
            case (req.reg_index)
                REG_CFG_LOW:
                    config_low_next = (config_low_reg & keep_low)
                                    | (req.write_data & ~keep_low);
                REG_CFG_HIGH:
                    config_high_next = (config_high_reg & keep_high)
                                     | (req.write_data & ~keep_high);
                REG_OUTPUT:
                    output_latch_next = req.write_data[15:0] & PIN_MASK;
                REG_SET_RESET:
                    output_latch_next = ((output_latch_reg & ~req.write_data[31:16])
                                        | req.write_data[15:0]) & PIN_MASK;
                REG_RESET:
                    output_latch_next = output_latch_reg & ~req.write_data[15:0] & PIN_MASK;
                REG_LOCK:
                begin
                    if (!locked)
                    begin
                        if (lock_step_reg == LK_ARMED && !wr_key
                            && wr_mask == pending_mask_reg)
                        begin
                            lock_step_next = LK_CLEARED;
                        end
                        else if (lock_step_reg == LK_CLEARED && wr_key
                                 && wr_mask == pending_mask_reg)
                        begin
                            lock_step_next = LK_LOCKED;
                        end
                        else if (wr_key)
                        begin
                            lock_step_next    = LK_ARMED;
                            pending_mask_next = wr_mask;
                        end
                        else
                        begin
                            lock_step_next = LK_IDLE;
                        end
                        lock_mask_next = wr_mask;
                    end
                end
                default:
                begin
                end
            endcase
        end

        rsp_next.read_data     = rd;
        rsp_next.pins_driven   = output_latch_next;
        rsp_next.config_locked = (lock_step_next inside {LK_LOCKED, LK_KEYED});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            config_low_reg   <= CONFIG_RESET;
            config_high_reg  <= CONFIG_RESET;
            output_latch_reg <= 16'd0;
            lock_mask_reg    <= 16'd0;
            lock_key_reg     <= 1'b0;
            lock_step_reg    <= LK_IDLE;
            pending_mask_reg <= 16'd0;
        end
        else if (cmd.accept)
        begin
            config_low_reg   <= config_low_next;
            config_high_reg  <= config_high_next;
            output_latch_reg <= output_latch_next;
            lock_mask_reg    <= lock_mask_next;
            lock_key_reg     <= lock_key_next;
            lock_step_reg    <= lock_step_next;
            pending_mask_reg <= pending_mask_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign rsp = rsp_reg;

`ifndef SYNTHESIS
    // Once locked, the port stays locked until reset.
    a_lock_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        locked |=> locked)
        else $error("lock released without reset");

    // The lock mask is frozen while the port is locked.
    a_mask_frozen: assert property (@(posedge clk) disable iff (!rst_n)
        locked |=> lock_mask_reg == $past(lock_mask_reg))
        else $error("lock mask changed while locked");

    // The key bit only reads back after the first lock read in the locked state.
    a_key_step: assert property (@(posedge clk) disable iff (!rst_n)
        lock_key_reg |-> lock_step_reg == LK_KEYED)
        else $error("key bit set outside the keyed step");

    // Locked configuration nibbles survive a config low write.
    a_cfg_guard: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.accept && locked && req.op == OP_WRITE && req.reg_index == REG_CFG_LOW)
        |=> (config_low_reg & $past(keep_low)) == ($past(config_low_reg) & $past(keep_low)))
        else $error("locked configuration nibble overwritten");
`endif

endmodule

FILE: rtl/core/gpio_port_register_block_top.sv
// GPIO port register block top level: 16 pins behind seven word registers with lock.
// A result appears in the cycle after its request is accepted, from the result register.
// Throughput: one request per cycle while results are taken; the next request enters while the result leaves.
// The controller holds at most one result; a stalled result stops new requests.
// Reset (rst_n, asynchronous, active low) sets config words to 0x44444444, clears the
// output latch, lock mask, key bit and lock sequence, and empties the result register.
module gpio_port_register_block_top
    import gprb_pkg::*;
(
    input logic         clk,
    input logic         rst_n,
    gprb_req_if.sink    req,
    gprb_rsp_if.source  rsp
);

    cmd_t cmd;
    logic req_ready;
    logic rsp_valid;
    rsp_t rsp_payload;

    gprb_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req_ready),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp.ready),
        .cmd       (cmd)
    );

    gprb_datapath u_datapath (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .req   (req.payload),
        .rsp   (rsp_payload)
    );

    assign req.ready   = req_ready;
    assign rsp.valid   = rsp_valid;
    assign rsp.payload = rsp_payload;

endmodule

FILE: verif/gpio_port_register_block_top_test.sv
// Self-checking testbench for the GPIO port register block: registers, lock and flow control.
`timescale 1ns / 1ps

module gpio_port_register_block_top_test;
    import gprb_pkg::*;

    logic clk = 1'b0;
    logic rst_n;

    gprb_req_if req_ch();
    gprb_rsp_if rsp_ch();

    gpio_port_register_block_top uut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch.sink),
        .rsp   (rsp_ch.source)
    );

    always #2 clk = ~clk;

    // Predicted port state.
    logic [31:0] cfg_low_q;
    logic [31:0] cfg_high_q;
    logic [15:0] out_latch_q;
    logic [15:0] lock_mask_q;
    logic        lock_key_q;
    logic [2:0]  lock_step;
    logic [15:0] armed_mask;

    rsp_t expected_results[$];

    int  error_count = 0;
    int  reads_sent = 0;
    int  writes_sent = 0;
    int  results_checked = 0;
    int  hold_left = 0;
    int  stall_left = 0;
    bit  send_idle = 1'b1;
    bit  recv_idle = 1'b1;
    logic [15:0] locked_pins;

    // Keep the nibbles of locked pins from the old word.
    function automatic logic [31:0] merge_config(logic [31:0] old_word, logic [31:0] new_word,
                                                 logic [7:0] pin_sel);
        logic [31:0] keep;
        keep = '0;
        if (lock_step >= LK_LOCKED)
        begin
            for (int i = 0; i < 8; i++)
            begin
                if (pin_sel[i])
                    keep[4*i +: 4] = NIBBLE;
            end
        end
        return (old_word & keep) | (new_word & ~keep);
    endfunction

    function automatic rsp_t gpio_predict(req_t r);
        rsp_t        o;
        logic [31:0] rd;
        logic [15:0] wmask;
        logic        wkey;
        rd = '0;
        if (r.op == OP_READ)
        begin
            case (r.reg_index)
                REG_CFG_LOW:  rd = cfg_low_q;
                REG_CFG_HIGH: rd = cfg_high_q;
                REG_INPUT:    rd = {16'h0, r.pin_levels & PIN_MASK};
                REG_OUTPUT:   rd = {16'h0, out_latch_q};
                REG_LOCK:
                begin
                    rd = {15'h0, lock_key_q, lock_mask_q};
                    // The key bit becomes visible only from the second read after locking.
                    if (lock_step == LK_LOCKED)
                    begin
                        lock_key_q = 1'b1;
                        lock_step = LK_KEYED;
                    end
                end
                default:      rd = '0;
            endcase
        end
        else
        begin
            case (r.reg_index)
                REG_CFG_LOW:   cfg_low_q = merge_config(cfg_low_q, r.write_data, lock_mask_q[7:0]);
                REG_CFG_HIGH:  cfg_high_q = merge_config(cfg_high_q, r.write_data,
                                                         lock_mask_q[15:8]);
                REG_OUTPUT:    out_latch_q = r.write_data[15:0] & PIN_MASK;
                REG_SET_RESET: out_latch_q = ((out_latch_q & ~r.write_data[31:16])
                                              | r.write_data[15:0]) & PIN_MASK;
                REG_RESET:     out_latch_q = out_latch_q & ~r.write_data[15:0] & PIN_MASK;
                REG_LOCK:
                begin
                    wmask = r.write_data[15:0] & PIN_MASK;
                    wkey = r.write_data[KEY_POS];
                    if (lock_step < LK_LOCKED)
                    begin
                        if (lock_step == LK_ARMED && !wkey && wmask == armed_mask)
                            lock_step = LK_CLEARED;
                        else if (lock_step == LK_CLEARED && wkey && wmask == armed_mask)
                            lock_step = LK_LOCKED;
                        else if (wkey)
                        begin
                            lock_step = LK_ARMED;
                            armed_mask = wmask;
                        end
                        else
                            lock_step = LK_IDLE;
                        lock_mask_q = wmask;
                    end
                end
                default: ;
            endcase
        end
        o.read_data = rd;
        o.pins_driven = out_latch_q;
        o.config_locked = (lock_step >= LK_LOCKED);
        return o;
    endfunction

    function automatic req_t make_request(logic op, logic [2:0] idx, logic [31:0] wdata,
                                          logic [15:0] pins);
        req_t r;
        r.op = op;
        r.reg_index = idx;
        r.write_data = wdata;
        r.pin_levels = pins;
        return r;
    endfunction

    // Lock writes mostly follow the key sequence from the current step; the rest is noise.
    function automatic req_t random_request(bit allow_lock);
        req_t r;
        int   pick;
        r.op = 1'($urandom_range(0, 1));
        pick = $urandom_range(0, 8);
        r.reg_index = (pick == 8) ? REG_LOCK : 3'(pick);
        r.write_data = $urandom;
        r.pin_levels = 16'($urandom);
        if (r.op == OP_WRITE && r.reg_index == REG_LOCK && $urandom_range(0, 3) != 0)
        begin
            case (lock_step)
                LK_ARMED:
                begin
                    r.write_data[15:0] = armed_mask;
                    r.write_data[KEY_POS] = 1'b0;
                end
                LK_CLEARED:
                begin
                    r.write_data[15:0] = armed_mask;
                    r.write_data[KEY_POS] = 1'b1;
                end
                default:
                begin
                    pick = $urandom_range(0, 5);
                    if (pick == 0)
                        r.write_data[15:0] = 16'h0000;
                    else if (pick == 1)
                        r.write_data[15:0] = 16'hFFFF;
                    r.write_data[KEY_POS] = 1'b1;
                end
            endcase
        end
        if (!allow_lock && r.op == OP_WRITE && r.reg_index == REG_LOCK
            && lock_step == LK_CLEARED && r.write_data[KEY_POS]
            && (r.write_data[15:0] & PIN_MASK) == armed_mask)
        begin
            if ($urandom_range(0, 1) == 0)
                r.write_data[KEY_POS] = 1'b0;
            else
                r.write_data[5'($urandom_range(0, 15))] ^= 1'b1;
        end
        return r;
    endfunction

    task automatic send_request(req_t r);
        @(negedge clk);
        if (send_idle && $urandom_range(0, 7) == 0)
        begin
            req_ch.valid = 1'b0;
            repeat ($urandom_range(1, 18)) @(negedge clk);
        end
        req_ch.valid = 1'b1;
        req_ch.payload = r;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        expected_results.push_back(gpio_predict(r));
        if (r.op == OP_READ)
            reads_sent++;
        else
            writes_sent++;
    endtask

    task automatic wait_results_drained();
        @(negedge clk);
        req_ch.valid = 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    task automatic test_register_access();
        send_request(make_request(OP_READ, REG_CFG_LOW, 32'h0, 16'h1234));
        send_request(make_request(OP_READ, REG_CFG_HIGH, 32'hFFFF_FFFF, 16'h0));
        send_request(make_request(OP_READ, REG_INPUT, 32'h0, 16'h0000));
        send_request(make_request(OP_WRITE, REG_INPUT, 32'hFFFF_FFFF, 16'h0000));
        send_request(make_request(OP_READ, REG_INPUT, 32'h0, 16'hFFFF));
        send_request(make_request(OP_WRITE, REG_OUTPUT, 32'hFFFF_FFFF, 16'h0));
        // Set and clear of the same bits: the set half wins.
        send_request(make_request(OP_WRITE, REG_SET_RESET, 32'hFFFF_FFFF, 16'h0));
        send_request(make_request(OP_WRITE, REG_SET_RESET, 32'hFFFF_0000, 16'h0));
        send_request(make_request(OP_WRITE, REG_SET_RESET, 32'h0000_A5A5, 16'h0));
        send_request(make_request(OP_WRITE, REG_RESET, 32'hFFFF_00F0, 16'h0));
        send_request(make_request(OP_READ, REG_SET_RESET, 32'h0, 16'hFFFF));
        send_request(make_request(OP_READ, REG_RESET, 32'h0, 16'hFFFF));
        send_request(make_request(OP_WRITE, REG_CFG_LOW, 32'hFFFF_FFFF, 16'h0));
        send_request(make_request(OP_WRITE, REG_CFG_HIGH, 32'h0000_0000, 16'h0));
    endtask

    task automatic test_lock_deviation();
        send_request(make_request(OP_WRITE, REG_LOCK, {15'h0, 1'b1, 16'h00FF}, 16'h0));
        send_request(make_request(OP_READ, REG_LOCK, 32'h0, 16'h0));
        // A second key write while armed restarts the sequence with its own mask.
        send_request(make_request(OP_WRITE, REG_LOCK, {15'h7FFF, 1'b1, 16'h00FF}, 16'h0));
        send_request(make_request(OP_WRITE, REG_LOCK, {15'h0, 1'b0, 16'h0F00}, 16'h0));
        send_request(make_request(OP_WRITE, REG_LOCK, {15'h0, 1'b1, 16'hFFFF}, 16'h0));
        send_request(make_request(OP_WRITE, REG_LOCK, {15'h0, 1'b0, 16'hFFFF}, 16'h0));
        send_request(make_request(OP_READ, REG_LOCK, 32'h0, 16'h0));
        send_request(make_request(OP_WRITE, REG_LOCK, {15'h0, 1'b0, 16'hFFFF}, 16'h0));
        send_request(make_request(OP_WRITE, REG_LOCK, {15'h0, 1'b1, 16'h1234}, 16'h0));
        send_request(make_request(OP_WRITE, REG_LOCK, {15'h0, 1'b0, 16'h1234}, 16'h0));
        send_request(make_request(OP_WRITE, REG_LOCK, {15'h0, 1'b1, 16'h4321}, 16'h0));
    endtask

    task automatic test_random_traffic(int count);
        repeat (count) send_request(random_request(1'b0));
    endtask

    // The receiver holds off while the sender keeps offering requests.
    task automatic test_backpressure_hold();
        send_idle = 1'b0;
        hold_left = 80;
        repeat (30) send_request(random_request(1'b0));
        send_idle = 1'b1;
    endtask

    task automatic test_pause_until_drained();
        repeat (25) send_request(random_request(1'b0));
        wait_results_drained();
        repeat (25) send_request(random_request(1'b0));
    endtask

    task automatic test_locked_port(int count);
        logic [31:0] wd;
        locked_pins = 16'($urandom);
        wd = $urandom;
        wd[15:0] = locked_pins;
        wd[KEY_POS] = 1'b1;
        send_request(make_request(OP_WRITE, REG_LOCK, wd, 16'($urandom)));
        wd = $urandom;
        wd[15:0] = locked_pins;
        wd[KEY_POS] = 1'b0;
        send_request(make_request(OP_WRITE, REG_LOCK, wd, 16'($urandom)));
        wd = $urandom;
        wd[15:0] = locked_pins;
        wd[KEY_POS] = 1'b1;
        send_request(make_request(OP_WRITE, REG_LOCK, wd, 16'($urandom)));
        send_request(make_request(OP_READ, REG_LOCK, 32'h0, 16'h0));
        send_request(make_request(OP_READ, REG_LOCK, 32'h0, 16'h0));
        send_request(make_request(OP_WRITE, REG_CFG_LOW, 32'hFFFF_FFFF, 16'h0));
        send_request(make_request(OP_WRITE, REG_CFG_HIGH, 32'hFFFF_FFFF, 16'h0));
        send_request(make_request(OP_READ, REG_CFG_LOW, 32'h0, 16'h0));
        send_request(make_request(OP_READ, REG_CFG_HIGH, 32'h0, 16'h0));
        send_request(make_request(OP_WRITE, REG_CFG_LOW, 32'h0000_0000, 16'h0));
        send_request(make_request(OP_WRITE, REG_CFG_HIGH, 32'h0000_0000, 16'h0));
        send_request(make_request(OP_WRITE, REG_LOCK, {15'h0, 1'b1, 16'h0000}, 16'h0));
        send_request(make_request(OP_READ, REG_LOCK, 32'h0, 16'h0));
        // The last stretch runs at full rate on both sides.
        send_idle = 1'b0;
        recv_idle = 1'b0;
        repeat (count) send_request(random_request(1'b1));
    endtask

    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            rsp_ch.ready = 1'b0;
            hold_left--;
        end
        else
        begin
            if (recv_idle && stall_left == 0 && $urandom_range(0, 9) == 0)
                stall_left = $urandom_range(1, 18);
            if (stall_left > 0)
            begin
                rsp_ch.ready = 1'b0;
                stall_left--;
            end
            else
                rsp_ch.ready = 1'b1;
        end
    end

    always @(posedge clk)
    begin
        rsp_t want;
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            if (expected_results.size() == 0)
            begin
                $error("result arrived with no request outstanding");
                error_count++;
            end
            else
            begin
                want = expected_results.pop_front();
                results_checked++;
                if (rsp_ch.payload.read_data !== want.read_data)
                begin
                    $error("read_data: expected %h, actual %h", want.read_data,
                           rsp_ch.payload.read_data);
                    error_count++;
                end
                if (rsp_ch.payload.pins_driven !== want.pins_driven)
                begin
                    $error("pins_driven: expected %h, actual %h", want.pins_driven,
                           rsp_ch.payload.pins_driven);
                    error_count++;
                end
                if (rsp_ch.payload.config_locked !== want.config_locked)
                begin
                    $error("config_locked: expected %b, actual %b", want.config_locked,
                           rsp_ch.payload.config_locked);
                    error_count++;
                end
            end
        end
    end

    initial
    begin
        rst_n = 1'b0;
        req_ch.valid = 1'b0;
        req_ch.payload = '0;
        rsp_ch.ready = 1'b0;
        cfg_low_q = CONFIG_RESET;
        cfg_high_q = CONFIG_RESET;
        out_latch_q = '0;
        lock_mask_q = '0;
        lock_key_q = 1'b0;
        lock_step = LK_IDLE;
        armed_mask = '0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_register_access();
        test_lock_deviation();
        test_backpressure_hold();
        test_random_traffic(300);
        test_pause_until_drained();
        test_random_traffic(250);
        test_locked_port(250);

        wait_results_drained();
        if (expected_results.size() != 0)
        begin
            $error("%0d expected results never arrived", expected_results.size());
            error_count++;
        end
        $display("Run covered %0d reads and %0d writes, %0d results checked, with random idling,",
                 reads_sent, writes_sent, results_checked);
        $display("a long result hold-off, a drain pause and a final lock of pin mask %h.",
                 locked_pins);
        if (error_count == 0)
            $display("PASS gpio_port_register_block_top");
        else
            $display("FAIL gpio_port_register_block_top");
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("FAIL gpio_port_register_block_top");
        $finish;
    end

endmodule

FILE: gpio_port_register_block_top.f
rtl/core/gprb_pkg.sv
rtl/core/gprb_if.sv
rtl/core/gprb_ctrl.sv
rtl/core/gprb_datapath.sv
rtl/core/gpio_port_register_block_top.sv
verif/gpio_port_register_block_top_test.sv
